/* rtl/core/tgc_pkg.sv */
package tgc_pkg;

  // Default timer width for press and mode counters
  localparam int unsigned TIMER_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned LVL_W     = 3;

  // Result queue depth; an item may push two entries
  localparam int unsigned EVQ_DEPTH = 4;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1500;
  localparam logic [CFG_W-1:0] MODE_TIMEOUT_RST = 16'd5000;
  localparam logic [CFG_W-1:0] MIN_PRESS_RST    = 16'd100;

  localparam logic [LVL_W-1:0] LVL_MIN = 3'd1;
  localparam logic [LVL_W-1:0] LVL_MAX = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_MODE_TIMEOUT = 2'd1,
    CFG_MIN_PRESS    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_SHORT = 2'd0,
    EV_LONG  = 2'd1,
    EV_STEP  = 2'd2,
    EV_EXIT  = 2'd3
  } ev_type_e;

  typedef struct packed {
    ev_type_e          event_type;
    logic [DUR_W-1:0]  press_dur;
    logic [PCT_W-1:0]  bright_pct;
    logic              last;
  } event_t;

  // Brightness percent for a level 1..5 (20 % a step)
  function automatic logic [PCT_W-1:0] level_pct(input logic [LVL_W-1:0] lvl);
    logic [PCT_W-1:0] pct;
    case (lvl)
      3'd1:    pct = 7'd20;
      3'd2:    pct = 7'd40;
      3'd3:    pct = 7'd60;
      3'd4:    pct = 7'd80;
      3'd5:    pct = 7'd100;
      default: pct = 7'd0;
    endcase
    return pct;
  endfunction

  // Cyclic step 1..5; codes above 5 fold back as 6 -> 2, 7 -> 3
  function automatic logic [LVL_W-1:0] level_next(input logic [LVL_W-1:0] lvl);
    logic [LVL_W-1:0] nxt;
    if (lvl == LVL_MAX) begin
      nxt = LVL_MIN;
    end else if (lvl > LVL_MAX) begin
      nxt = lvl - (LVL_MAX - LVL_MIN);
    end else begin
      nxt = lvl + 3'd1;
    end
    return nxt;
  endfunction

endpackage

/* rtl/core/tgc_in_if.sv */
interface tgc_in_if;
  logic valid;
  logic ready;
  logic touch_level;

  modport source (output valid, output touch_level, input ready);
  modport sink   (input valid, input touch_level, output ready);
endinterface

/* rtl/core/tgc_out_if.sv */
interface tgc_out_if;
  logic                        valid;
  logic                        ready;
  tgc_pkg::ev_type_e           event_type;
  logic [tgc_pkg::DUR_W-1:0]   press_dur;
  logic [tgc_pkg::PCT_W-1:0]   bright_pct;
  logic                        last;

  modport source (output valid, output event_type, output press_dur,
                  output bright_pct, output last, input ready);
  modport sink   (input valid, input event_type, input press_dur,
                  input bright_pct, input last, output ready);
endinterface

/* rtl/core/touch_gesture_classifier.sv */
// Touch gesture classifier: short press, long press and brightness mode.
// in_i carries one request per millisecond tick: the sampled touch level.
// out_o carries event requests: short press (with duration), long press,
// brightness step (new percent) and brightness exit; last marks the final
// event caused by a tick. A tick causes zero, one or two events.
// Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) set long-press time,
// mode timeout and minimum press time; write them only while idle.
// Timing: the tick's state update and events are worked out in the
// accepting cycle and written to a 4-entry result queue, which offers them
// on out_o oldest first. Throughput: one tick per clock while ticks cause
// at most one event each and out_o.ready stays high; the out side drains
// one event per clock when ready, bounding the rate of event-causing ticks.
// in_i.ready is high while the queue has room for two events, so a tick is
// taken while earlier events still wait. A stalled receiver fills the
// queue and then holds off ticks; nothing is dropped.
// Reset (rst_ni low, asynchronous) empties the queue, clears the gesture
// state, sets the level to 1 and loads the registers with 1500, 5000, 100.
module touch_gesture_classifier #(
  parameter int unsigned TIMER_BITS = tgc_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tgc_in_if.sink                          in_i,
  tgc_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tgc_pkg::CFG_W-1:0]       cfg_wdata_i
);

  // compare width covers both timers and 16-bit registers
  localparam int unsigned CW    = (TIMER_BITS > tgc_pkg::CFG_W) ? TIMER_BITS : tgc_pkg::CFG_W;
  localparam int unsigned DEPTH = tgc_pkg::EVQ_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // ---------------- configuration registers ----------------
  logic [tgc_pkg::CFG_W-1:0] long_press_q, mode_timeout_q, min_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q   <= tgc_pkg::LONG_PRESS_RST;
      mode_timeout_q <= tgc_pkg::MODE_TIMEOUT_RST;
      min_press_q    <= tgc_pkg::MIN_PRESS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tgc_pkg::CFG_LONG_PRESS:   long_press_q   <= cfg_wdata_i;
        tgc_pkg::CFG_MODE_TIMEOUT: mode_timeout_q <= cfg_wdata_i;
        tgc_pkg::CFG_MIN_PRESS:    min_press_q    <= cfg_wdata_i;
        default: ;  // unused index: ignored
      endcase
    end
  end

  // ---------------- gesture state ----------------
  logic                       pressed_q, pressed_d;
  logic                       mode_q, mode_d;
  logic                       fired_q, fired_d;
  logic                       armed_q, armed_d;
  logic [tgc_pkg::LVL_W-1:0]  lvl_q, lvl_d;
  logic [TIMER_BITS-1:0]      press_el_q, press_el_d;
  logic [TIMER_BITS-1:0]      mode_el_q, mode_el_d;

  // ---------------- result queue ----------------
  tgc_pkg::event_t      evq_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q;

  logic in_fire, out_fire;
  assign in_i.ready = (cnt_q <= CNT_W'(DEPTH - 2));
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_o.valid = (cnt_q != '0);
  assign out_fire   = out_o.valid & out_o.ready;

  // ---------------- tick evaluation ----------------
  logic [TIMER_BITS-1:0] p_el, m_el, m_el1;
  logic                  long_hit, long_ev, mode1, fired1, armed1, exit_ev, mode2;
  logic                  rise, fall, lvl_ev;
  tgc_pkg::event_t       ev_long, ev_exit, ev_lvl, slot0, slot1;
  logic [1:0]            n_ev;

  always_comb begin
    // counters of a running press / active mode advance, saturating
    p_el = (pressed_q && !(&press_el_q)) ? press_el_q + 1'b1 : press_el_q;
    m_el = (mode_q && !(&mode_el_q)) ? mode_el_q + 1'b1 : mode_el_q;

    // long-press expiry
    long_hit = armed_q && (CW'(p_el) >= CW'(long_press_q));
    long_ev  = long_hit && pressed_q && !mode_q;
    armed1   = armed_q & ~long_hit;
    mode1    = mode_q | long_ev;
    fired1   = fired_q | long_ev;
    m_el1    = long_ev ? '0 : m_el;

    // mode timeout
    exit_ev = mode1 && (CW'(m_el1) >= CW'(mode_timeout_q));
    mode2   = mode1 & ~exit_ev;

    pressed_d  = pressed_q;
    mode_d     = mode2;
    fired_d    = fired1;
    armed_d    = armed1;
    lvl_d      = lvl_q;
    press_el_d = p_el;
    mode_el_d  = exit_ev ? '0 : m_el1;

    ev_long = '{event_type: tgc_pkg::EV_LONG, press_dur: long_press_q,
                bright_pct: '0, last: 1'b0};
    ev_exit = '{event_type: tgc_pkg::EV_EXIT, press_dur: '0,
                bright_pct: '0, last: 1'b0};
    // short press by default; duration saturates at 16 bits
    ev_lvl  = '{event_type: tgc_pkg::EV_SHORT,
                press_dur: (CW'(p_el) > CW'({tgc_pkg::DUR_W{1'b1}}))
                           ? {tgc_pkg::DUR_W{1'b1}} : tgc_pkg::DUR_W'(p_el),
                bright_pct: '0, last: 1'b0};
    lvl_ev  = 1'b0;

    rise = in_i.touch_level & ~pressed_q;
    fall = ~in_i.touch_level & pressed_q;

    if (rise) begin
      pressed_d  = 1'b1;
      fired_d    = 1'b0;
      press_el_d = '0;
      armed_d    = ~mode2;
    end else if (fall) begin
      pressed_d = 1'b0;
      armed_d   = 1'b0;
      if (fired1) begin
        fired_d = 1'b0;  // release after a long press: silent
      end else if (CW'(p_el) >= CW'(min_press_q)) begin
        lvl_ev = 1'b1;
        if (mode2) begin
          lvl_d     = tgc_pkg::level_next(lvl_q);
          mode_el_d = '0;
          ev_lvl    = '{event_type: tgc_pkg::EV_STEP, press_dur: '0,
                        bright_pct: tgc_pkg::level_pct(lvl_d), last: 1'b0};
        end
      end
    end

    // at most two events: long+exit or exit+level
    n_ev  = 2'(long_ev) + 2'(exit_ev) + 2'(lvl_ev);
    slot0 = long_ev ? ev_long : (exit_ev ? ev_exit : ev_lvl);
    slot1 = long_ev ? ev_exit : ev_lvl;
    slot0.last = (n_ev == 2'd1);
    slot1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q  <= 1'b0;
      mode_q     <= 1'b0;
      fired_q    <= 1'b0;
      armed_q    <= 1'b0;
      lvl_q      <= tgc_pkg::LVL_MIN;
      press_el_q <= '0;
      mode_el_q  <= '0;
    end else if (in_fire) begin
      pressed_q  <= pressed_d;
      mode_q     <= mode_d;
      fired_q    <= fired_d;
      armed_q    <= armed_d;
      lvl_q      <= lvl_d;
      press_el_q <= press_el_d;
      mode_el_q  <= mode_el_d;
    end
  end

  // queue payload: no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && n_ev != 2'd0) begin
      evq_q[wr_ptr_q] <= slot0;
    end
    if (in_fire && n_ev == 2'd2) begin
      evq_q[wr_ptr_q + PTR_W'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(n_ev);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + (in_fire ? CNT_W'(n_ev) : '0) - CNT_W'(out_fire);
    end
  end

  assign out_o.event_type = evq_q[rd_ptr_q].event_type;
  assign out_o.press_dur  = evq_q[rd_ptr_q].press_dur;
  assign out_o.bright_pct = evq_q[rd_ptr_q].bright_pct;
  assign out_o.last       = evq_q[rd_ptr_q].last;

  // ---------------- assertions ----------------
  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // long-press timer only runs during a press outside brightness mode
  a_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (pressed_q && !mode_q))
    else $error("long-press timer armed in wrong state");

  // level stays in 1..5
  a_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_q >= tgc_pkg::LVL_MIN) && (lvl_q <= tgc_pkg::LVL_MAX))
    else $error("brightness level out of range");

  // a two-event tick never opens with a short press, and a long press never shares a tick with a level event
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && n_ev == 2'd2) |-> (slot0.event_type != tgc_pkg::EV_SHORT &&
                                   !(long_ev && lvl_ev)))
    else $error("impossible event pair");

endmodule

/* sim/touch_gesture_classifier_tb.sv */
`timescale 1ns / 100ps

module touch_gesture_classifier_tb;

  // Spare register index: the block must ignore writes to it
  localparam logic [tgc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Ticks in the random part
  localparam int RAND_TICKS  = 700;
  // Tail of the random part that runs without any idling
  localparam int CALM_TICKS  = 200;
  // Cycles the block may need to settle once nothing is owed
  localparam int SETTLE      = 4;
  // Cycles without any request moving on either side before giving up
  localparam int QUIET_LIMIT = 1000;

  localparam tgc_pkg::event_t NO_EV = '0;

  // Directed plan: a row either holds one level for a number of ticks, or
  // writes a register once the block has gone quiet. A typed result, where
  // given, stands for what the last tick of the row must produce.
  typedef enum logic {
    ROW_TICKS,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e                       kind;
    logic                            lvl;
    logic [16:0]                     reps;
    logic [tgc_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [tgc_pkg::CFG_W-1:0]       reg_val;
    logic                            typed;
    tgc_pkg::event_t                 ev;
  } plan_row_t;

  localparam plan_row_t DIR_PLAN [0:32] = '{
    // Defaults after reset: a press of exactly the minimum time
    '{ROW_TICKS, 1'b1, 17'd100, CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b1,
      '{tgc_pkg::EV_SHORT, 16'd100, 7'd0, 1'b1}},
    // One tick short of the minimum: nothing reported
    '{ROW_TICKS, 1'b1, 17'd99,  CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    // Shorter hold, timeout and minimum for the mode rows
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_LONG_PRESS,   16'd20,   1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MODE_TIMEOUT, 16'd50,   1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MIN_PRESS,    16'd5,    1'b0, NO_EV},
    // Long press at the hold time, then a silent release
    '{ROW_TICKS, 1'b1, 17'd21,  CFG_SPARE,                 16'd0,    1'b1,
      '{tgc_pkg::EV_LONG, 16'd20, 7'd0, 1'b1}},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    // Press inside brightness mode steps the level from 20 to 40 percent
    '{ROW_TICKS, 1'b1, 17'd5,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b1,
      '{tgc_pkg::EV_STEP, 16'd0, 7'd40, 1'b1}},
    // Mode left alone for the full timeout
    '{ROW_TICKS, 1'b0, 17'd50,  CFG_SPARE,                 16'd0,    1'b1,
      '{tgc_pkg::EV_EXIT, 16'd0, 7'd0, 1'b1}},
    // All times zero; spare index written with ones
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_LONG_PRESS,   16'd0,    1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MODE_TIMEOUT, 16'd0,    1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MIN_PRESS,    16'd0,    1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   CFG_SPARE,                 16'hFFFF, 1'b0, NO_EV},
    // Long press and mode exit on the same tick
    '{ROW_TICKS, 1'b1, 17'd2,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    // Shortest possible press counts with a zero minimum
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_LONG_PRESS,   16'd5,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b1, 17'd1,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b1,
      '{tgc_pkg::EV_SHORT, 16'd1, 7'd0, 1'b1}},
    // All times at full scale: a long hold is neither long nor counted
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_LONG_PRESS,   16'hFFFF, 1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MODE_TIMEOUT, 16'hFFFF, 1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MIN_PRESS,    16'hFFFF, 1'b0, NO_EV},
    '{ROW_TICKS, 1'b1, 17'd300, CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    // Enter mode quickly, press inside it and hold past the mode timeout:
    // reported as a short press
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_LONG_PRESS,   16'd1,    1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MODE_TIMEOUT, 16'd10,   1'b0, NO_EV},
    '{ROW_WRITE, 1'b0, 17'd0,   tgc_pkg::CFG_MIN_PRESS,    16'd3,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b1, 17'd2,   CFG_SPARE,                 16'd0,    1'b1,
      '{tgc_pkg::EV_LONG, 16'd1, 7'd0, 1'b1}},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b1, 17'd40,  CFG_SPARE,                 16'd0,    1'b0, NO_EV},
    '{ROW_TICKS, 1'b0, 17'd1,   CFG_SPARE,                 16'd0,    1'b1,
      '{tgc_pkg::EV_SHORT, 16'd40, 7'd0, 1'b1}}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tgc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tgc_pkg::CFG_W-1:0]     cfg_wdata;

  tgc_in_if  tick_if ();
  tgc_out_if event_if ();

  touch_gesture_classifier u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (tick_if),
    .out_o      (event_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Gesture state as the block should hold it
  logic                      gs_pressed;
  logic                      gs_mode;
  logic                      gs_long_fired;
  logic                      gs_long_armed;
  logic [tgc_pkg::LVL_W-1:0] gs_level;
  logic [tgc_pkg::DUR_W-1:0] gs_press_cnt;
  logic [tgc_pkg::DUR_W-1:0] gs_mode_cnt;

  // Register shadow
  logic [tgc_pkg::CFG_W-1:0] hold_ticks;
  logic [tgc_pkg::CFG_W-1:0] idle_ticks;
  logic [tgc_pkg::CFG_W-1:0] min_ticks;

  // Events owed by the block, oldest first
  tgc_pkg::event_t events_q [$];

  int mismatch_cnt;
  int ticks_sent;
  int src_idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Works out the events of one tick and queues them. Order within a tick:
  // timers advance, long press expiry, mode timeout, then the level change.
  task automatic classify_tick(input logic lvl);
    tgc_pkg::event_t ev [2];
    int              n;
    n = 0;
    if (gs_pressed && gs_press_cnt != '1) gs_press_cnt++;
    if (gs_mode && gs_mode_cnt != '1) gs_mode_cnt++;

    if (gs_long_armed && gs_press_cnt >= hold_ticks) begin
      gs_long_armed = 1'b0;
      if (gs_pressed && !gs_mode) begin
        gs_mode       = 1'b1;
        gs_long_fired = 1'b1;
        gs_mode_cnt   = '0;
        ev[n] = '{tgc_pkg::EV_LONG, hold_ticks, 7'd0, 1'b0};
        n++;
      end
    end

    if (gs_mode && gs_mode_cnt >= idle_ticks) begin
      gs_mode     = 1'b0;
      gs_mode_cnt = '0;
      ev[n] = '{tgc_pkg::EV_EXIT, 16'd0, 7'd0, 1'b0};
      n++;
    end

    if (lvl && !gs_pressed) begin
      gs_pressed    = 1'b1;
      gs_long_fired = 1'b0;
      gs_press_cnt  = '0;
      // no long press timer while already in brightness mode
      gs_long_armed = !gs_mode;
    end else if (!lvl && gs_pressed) begin
      gs_pressed    = 1'b0;
      gs_long_armed = 1'b0;
      if (gs_long_fired) begin
        gs_long_fired = 1'b0;
      end else if (gs_press_cnt >= min_ticks) begin
        if (gs_mode) begin
          // cyclic 1..5, 20 % a step; a step restarts the mode timeout
          gs_level    = (gs_level == tgc_pkg::LVL_MAX) ? tgc_pkg::LVL_MIN : gs_level + 3'd1;
          gs_mode_cnt = '0;
          ev[n] = '{tgc_pkg::EV_STEP, 16'd0, 7'(gs_level * 7'd20), 1'b0};
        end else begin
          ev[n] = '{tgc_pkg::EV_SHORT, gs_press_cnt, 7'd0, 1'b0};
        end
        n++;
      end
    end

    for (int i = 0; i < n; i++) begin
      ev[i].last = (i == n - 1);
      events_q.push_back(ev[i]);
    end
  endtask

  // Offers one tick request, entered and left at a falling edge. A typed
  // result replaces whatever the predictor owes for this tick.
  task automatic send_tick(input logic lvl, input logic typed,
                           input tgc_pkg::event_t typed_ev);
    int owed;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      tick_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    tick_if.valid       = 1'b1;
    tick_if.touch_level = lvl;
    do @(posedge clk); while (tick_if.ready !== 1'b1);
    owed = events_q.size();
    classify_tick(lvl);
    if (typed) begin
      while (events_q.size() > owed) void'(events_q.pop_back());
      events_q.push_back(typed_ev);
    end
    ticks_sent++;
    @(negedge clk);
  endtask

  // Drops valid and lets every owed event drain, then a few cycles more
  // for a tick that causes nothing.
  task automatic drain_quiet();
    tick_if.valid = 1'b0;
    while (events_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tgc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tgc_pkg::CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      tgc_pkg::CFG_LONG_PRESS:   hold_ticks = val;
      tgc_pkg::CFG_MODE_TIMEOUT: idle_ticks = val;
      tgc_pkg::CFG_MIN_PRESS:    min_ticks  = val;
      default: ;
    endcase
  endtask

  // Receiver: ready low in random bursts, steady high when stall_pct is 0
  initial begin
    event_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        event_if.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      event_if.ready = 1'b1;
    end
  end

  // Result checker: every event leaving the block against the oldest owed
  always @(posedge clk) begin : check_events
    tgc_pkg::event_t want;
    if (rst_n && event_if.valid && event_if.ready) begin
      if (events_q.size() == 0) begin
        report_mismatch($sformatf("event with none owed: type %0d dur %0d pct %0d last %0d",
                                  event_if.event_type, event_if.press_dur,
                                  event_if.bright_pct, event_if.last));
      end else begin
        want = events_q.pop_front();
        if (event_if.event_type !== want.event_type)
          report_mismatch($sformatf("event_type got %0d want %0d",
                                    event_if.event_type, want.event_type));
        if (event_if.press_dur !== want.press_dur)
          report_mismatch($sformatf("press_dur got %0d want %0d",
                                    event_if.press_dur, want.press_dur));
        if (event_if.bright_pct !== want.bright_pct)
          report_mismatch($sformatf("bright_pct got %0d want %0d",
                                    event_if.bright_pct, want.bright_pct));
        if (event_if.last !== want.last)
          report_mismatch($sformatf("last got %0d want %0d", event_if.last, want.last));
      end
    end
  end

  // Watchdog: a run where no request moves for too long has hung
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((tick_if.valid && tick_if.ready) || (event_if.valid && event_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int hold;
    int gap;
    int phase_len;
    int phase_start;
    logic calm;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    tick_if.valid       = 1'b0;
    tick_if.touch_level = 1'b0;
    mismatch_cnt        = 0;
    ticks_sent          = 0;
    src_idle_pct        = 4;
    stall_pct           = 4;

    gs_pressed    = 1'b0;
    gs_mode       = 1'b0;
    gs_long_fired = 1'b0;
    gs_long_armed = 1'b0;
    gs_level      = tgc_pkg::LVL_MIN;
    gs_press_cnt  = '0;
    gs_mode_cnt   = '0;
    hold_ticks    = tgc_pkg::LONG_PRESS_RST;
    idle_ticks    = tgc_pkg::MODE_TIMEOUT_RST;
    min_ticks     = tgc_pkg::MIN_PRESS_RST;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed plan
    foreach (DIR_PLAN[r]) begin
      if (DIR_PLAN[r].kind == ROW_WRITE) begin
        drain_quiet();
        write_reg(DIR_PLAN[r].reg_idx, DIR_PLAN[r].reg_val);
      end else begin
        for (int k = 0; k < DIR_PLAN[r].reps; k++)
          send_tick(DIR_PLAN[r].lvl, DIR_PLAN[r].typed && (k == DIR_PLAN[r].reps - 1),
                    DIR_PLAN[r].ev);
      end
    end

    // Random phases: fresh short times each phase, mostly whole gestures
    // (press, hold, release, idle gap) so that long presses, steps and
    // timeouts all come round; one draw in ten is level noise.
    ticks_sent = 0;
    while (ticks_sent < RAND_TICKS) begin
      drain_quiet();
      calm = (ticks_sent >= RAND_TICKS - CALM_TICKS);
      case ($urandom_range(0, 2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 4;
        default: src_idle_pct = 20;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 4;
        default: stall_pct = 20;
      endcase
      if (calm) begin
        src_idle_pct = 0;
        stall_pct    = 0;
      end

      write_reg(tgc_pkg::CFG_LONG_PRESS, ($urandom_range(0, 5) == 0) ?
                16'($urandom_range(0, 1)) : 16'($urandom_range(2, 40)));
      write_reg(tgc_pkg::CFG_MODE_TIMEOUT, ($urandom_range(0, 5) == 0) ?
                16'($urandom_range(0, 1)) : 16'($urandom_range(2, 80)));
      write_reg(tgc_pkg::CFG_MIN_PRESS, ($urandom_range(0, 5) == 0) ?
                16'd0 : 16'($urandom_range(1, 15)));

      phase_len   = $urandom_range(120, 220);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < phase_len) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)), 1'b0, NO_EV);
        end else begin
          // hold counts the press tick itself; a long press fires on
          // tick hold_ticks + 1, or on tick 2 when hold_ticks is 0
          case ($urandom_range(0, 3))
            0:       hold = $urandom_range(1, int'(min_ticks) + 1);
            1:       hold = int'(hold_ticks) + $urandom_range(0, 2);
            2:       hold = $urandom_range(1, 2 * int'(hold_ticks) + 4);
            default: hold = int'(min_ticks) + $urandom_range(0, 3);
          endcase
          if (hold < 1) hold = 1;
          gap = $urandom_range(1, int'(idle_ticks) + 6);
          repeat (hold) send_tick(1'b1, 1'b0, NO_EV);
          repeat (gap) send_tick(1'b0, 1'b0, NO_EV);
        end
      end
    end

    drain_quiet();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tgc_pkg.sv
rtl/core/tgc_in_if.sv
rtl/core/tgc_out_if.sv
rtl/core/touch_gesture_classifier.sv
sim/touch_gesture_classifier_tb.sv
